FILE: hdl/rbsi_pkg.sv
// ----------------------------------------------------------------------------
// rbsi_pkg
// Shared types and constants for the ray / box slab intersection pipeline.
// ----------------------------------------------------------------------------
package rbsi_pkg;

    localparam int AXES    = 3;
    // Divider stages: operand prep, one stage per quotient bit, saturation.
    localparam int QBITS   = 32;
    localparam int DIV_LAT = QBITS + 2;

    // Extended slab value width; unbounded slabs use +/- 2^40.
    localparam int T_W = 42;
    localparam logic signed [T_W-1:0] T_POS_INF = T_W'(64'sh0000_0100_0000_0000);
    localparam logic signed [T_W-1:0] T_NEG_INF = -T_POS_INF;

    localparam logic [1:0] AXIS_X = 2'd0;

    typedef logic [AXES-1:0][31:0] t_vec3;

    // Per-ray data carried alongside the dividers.
    typedef struct packed {
        t_vec3           org;
        t_vec3           dir;
        logic [AXES-1:0] bounded;
        logic            miss;
    } t_side;

endpackage

FILE: hdl/ray_box_slab_intersect.sv
// ----------------------------------------------------------------------------
// ray_box_slab_intersect
// Ray versus axis-aligned box slab test with hit point and face normal.
// ----------------------------------------------------------------------------
// Takes one ray/box pair per cycle while not stalled and returns one result
// per pair, in order. The six pipelined dividers (one quotient bit per stage,
// 32 quotient stages) form the slab values; they are followed by min/max,
// near/far reduction, hit decision, point multiply and point
// add/clamp stages. The whole pipeline advances as one unit: it stalls only
// while a result sits in the output register and i_m_tready is low, so one
// transaction per cycle is sustained when the sink is always ready.
// Coordinates are signed fixed point with FRAC_BITS fraction bits.
module ray_box_slab_intersect
    import rbsi_pkg::*;
#(
    parameter int FRAC_BITS = 16
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    // input stream
    input  logic         i_s_tvalid,
    output logic         o_s_tready,
    // origin_x, origin_y, origin_z, dir_x, dir_y, dir_z,
    // box_min_x, box_min_y, box_min_z, box_max_x, box_max_y, box_max_z
    // (32 bits each, lowest first)
    input  logic [383:0] i_s_tdata,
    // result stream
    output logic         o_m_tvalid,
    input  logic         i_m_tready,
    // hit[0], inside_res[1], point_x[33:2], point_y[65:34], point_z[97:66],
    // normal_axis[99:98], normal_negative[100], overflow[101], zero pad
    output logic [103:0] o_m_tdata
);

    // Global advance: pipeline moves unless the output holds an untaken result.
    logic ce;
    logic r_v5;
    assign ce         = !r_v5 || i_m_tready;
    assign o_s_tready = ce;

    // ---- input unpack and zero-direction slab checks ----
    t_vec3 in_o, in_d, in_lo, in_hi;
    t_side in_side;
    always_comb begin
        for (int a = 0; a < AXES; a++) begin
            in_o[a]  = i_s_tdata[32*a      +: 32];
            in_d[a]  = i_s_tdata[32*(a+3)  +: 32];
            in_lo[a] = i_s_tdata[32*(a+6)  +: 32];
            in_hi[a] = i_s_tdata[32*(a+9)  +: 32];
        end
        in_side.org  = in_o;
        in_side.dir  = in_d;
        in_side.miss = 1'b0;
        for (int a = 0; a < AXES; a++) begin
            in_side.bounded[a] = in_d[a] != 32'd0;
            // zero direction: origin must lie strictly inside that slab
            if (in_d[a] == 32'd0 &&
                !($signed(in_lo[a]) < $signed(in_o[a]) &&
                  $signed(in_o[a]) < $signed(in_hi[a])))
                in_side.miss = 1'b1;
        end
    end

    // ---- slab dividers ----
    logic signed [31:0] q_lo [AXES];
    logic signed [31:0] q_hi [AXES];
    logic               v_lo [AXES];
    logic               v_hi [AXES];

    genvar g;
    generate
        for (g = 0; g < AXES; g++) begin : g_axis
            rbsi_div #(.FRAC_BITS(FRAC_BITS)) u_div_lo (
                .i_clk (i_clk),
                .i_ce  (ce),
                .i_num ({in_lo[g][31], in_lo[g]} - {in_o[g][31], in_o[g]}),
                .i_den (in_d[g]),
                .o_quot(q_lo[g]),
                .o_ovf (v_lo[g])
            );
            rbsi_div #(.FRAC_BITS(FRAC_BITS)) u_div_hi (
                .i_clk (i_clk),
                .i_ce  (ce),
                .i_num ({in_hi[g][31], in_hi[g]} - {in_o[g][31], in_o[g]}),
                .i_den (in_d[g]),
                .o_quot(q_hi[g]),
                .o_ovf (v_hi[g])
            );
        end
    endgenerate

    // ---- side data and valid delay matching the dividers ----
    t_side r_sd  [0:DIV_LAT-1];
    logic  r_vld [0:DIV_LAT-1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < DIV_LAT; i++) r_vld[i] <= 1'b0;
        end else if (ce) begin
            r_vld[0] <= i_s_tvalid;
            for (int i = 1; i < DIV_LAT; i++) r_vld[i] <= r_vld[i-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (ce) begin
            r_sd[0] <= in_side;
            for (int i = 1; i < DIV_LAT; i++) r_sd[i] <= r_sd[i-1];
        end
    end

    t_side sd;
    assign sd = r_sd[DIV_LAT-1];

    // ---- stage 1: per-axis slab min/max, quotient overflow ----
    logic        r_v1;
    t_side       r_s1;
    t_vec3       r_tlo1, r_thi1, r_mn1, r_mx1;
    logic        r_ovf1;
    t_vec3       n_mn1, n_mx1, n_tlo1, n_thi1;
    logic        n_ovf1;

    always_comb begin
        n_ovf1 = 1'b0;
        for (int a = 0; a < AXES; a++) begin
            n_tlo1[a] = q_lo[a];
            n_thi1[a] = q_hi[a];
            n_mn1[a]  = (q_lo[a] < q_hi[a]) ? q_lo[a] : q_hi[a];
            n_mx1[a]  = (q_lo[a] < q_hi[a]) ? q_hi[a] : q_lo[a];
            if (sd.bounded[a] && (v_lo[a] || v_hi[a])) n_ovf1 = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (ce) begin
            r_s1   <= sd;
            r_tlo1 <= n_tlo1;
            r_thi1 <= n_thi1;
            r_mn1  <= n_mn1;
            r_mx1  <= n_mx1;
            r_ovf1 <= n_ovf1;
        end
    end

    // ---- stage 2: near = max of minima, far = min of maxima ----
    logic                  r_v2;
    t_side                 r_s2;
    t_vec3                 r_tlo2, r_thi2;
    logic                  r_ovf2;
    logic signed [T_W-1:0] r_near2, r_far2;
    logic signed [T_W-1:0] n_near2, n_far2, e_mn, e_mx;

    always_comb begin
        n_near2 = T_NEG_INF;
        n_far2  = T_POS_INF;
        for (int a = 0; a < AXES; a++) begin
            e_mn = T_W'($signed(r_mn1[a]));
            e_mx = T_W'($signed(r_mx1[a]));
            if (r_s1.bounded[a] && e_mn > n_near2) n_near2 = e_mn;
            if (r_s1.bounded[a] && e_mx < n_far2)  n_far2  = e_mx;
        end
    end

    always_ff @(posedge i_clk) begin
        if (ce) begin
            r_s2    <= r_s1;
            r_tlo2  <= r_tlo1;
            r_thi2  <= r_thi1;
            r_ovf2  <= r_ovf1;
            r_near2 <= n_near2;
            r_far2  <= n_far2;
        end
    end

    // ---- stage 3: hit decision, chosen t, face normal ----
    logic        r_v3, r_hit3, r_in3, r_fin3, r_neg3, r_ovf3;
    logic [1:0]  r_axis3;
    logic [31:0] r_t3;
    t_vec3       r_o3, r_d3;
    logic        n_hit3, n_in3, n_fin3, n_neg3, found;
    logic [1:0]  n_axis3;
    logic signed [T_W-1:0] t_sel;

    always_comb begin
        n_hit3  = !r_s2.miss && (r_near2 < r_far2) && (r_far2 > 0) && (r_near2 != 0);
        n_in3   = r_near2 < 0;
        t_sel   = n_in3 ? r_far2 : r_near2;
        n_fin3  = n_in3 ? (r_far2 != T_POS_INF) : (r_near2 != T_NEG_INF);
        n_axis3 = AXIS_X;
        n_neg3  = 1'b0;
        found   = 1'b0;
        // face order: min x, max x, min y, max y, min z, max z
        for (int a = 0; a < AXES; a++) begin
            if (!found && r_s2.bounded[a]) begin
                if (T_W'($signed(r_tlo2[a])) == t_sel) begin
                    n_axis3 = 2'(a);
                    n_neg3  = !n_in3;
                    found   = 1'b1;
                end else if (T_W'($signed(r_thi2[a])) == t_sel) begin
                    n_axis3 = 2'(a);
                    n_neg3  = n_in3;
                    found   = 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (ce) begin
            r_hit3  <= n_hit3;
            r_in3   <= n_in3;
            r_fin3  <= n_fin3;
            r_axis3 <= n_axis3;
            r_neg3  <= n_neg3;
            r_t3    <= t_sel[31:0];
            r_o3    <= r_s2.org;
            r_d3    <= r_s2.dir;
            r_ovf3  <= r_ovf2;
        end
    end

    // ---- stage 4: dir * t products ----
    logic        r_v4, r_hit4, r_in4, r_fin4, r_neg4, r_ovf4;
    logic [1:0]  r_axis4;
    t_vec3       r_o4;
    logic signed [63:0] r_prod4 [AXES];

    always_ff @(posedge i_clk) begin
        if (ce) begin
            for (int a = 0; a < AXES; a++)
                r_prod4[a] <= $signed(r_d3[a]) * $signed(r_t3);
            r_hit4  <= r_hit3;
            r_in4   <= r_in3;
            r_fin4  <= r_fin3;
            r_axis4 <= r_axis3;
            r_neg4  <= r_neg3;
            r_o4    <= r_o3;
            r_ovf4  <= r_ovf3;
        end
    end

    // ---- stage 5: point = origin + floor(prod >> FRAC_BITS), clamped ----
    logic [103:0]       r_out5;
    logic [103:0]       n_out5;
    logic signed [64:0] sum;
    logic signed [63:0] shf;
    logic [31:0]        pnt [AXES];
    logic               povf;

    always_comb begin
        povf = 1'b0;
        for (int a = 0; a < AXES; a++) begin
            shf = r_prod4[a] >>> FRAC_BITS;
            sum = 65'($signed(r_o4[a])) + 65'(shf);
            pnt[a] = r_o4[a];
            if (r_fin4) begin
                if (sum > 65'sh0_7FFF_FFFF) begin
                    pnt[a] = 32'h7FFF_FFFF;
                    povf   = 1'b1;
                end else if (sum < -65'sh0_8000_0000) begin
                    pnt[a] = 32'h8000_0000;
                    povf   = 1'b1;
                end else begin
                    pnt[a] = sum[31:0];
                end
            end
        end
        n_out5 = '0;
        if (r_hit4) begin
            n_out5[0]      = 1'b1;
            n_out5[1]      = r_in4;
            n_out5[33:2]   = pnt[0];
            n_out5[65:34]  = pnt[1];
            n_out5[97:66]  = pnt[2];
            n_out5[99:98]  = r_axis4;
            n_out5[100]    = r_neg4;
        end
        n_out5[101] = r_ovf4 || (r_hit4 && povf);
    end

    always_ff @(posedge i_clk) begin
        if (ce) r_out5 <= n_out5;
    end

    // ---- valid bits through the post-divider stages ----
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
            r_v5 <= 1'b0;
        end else if (ce) begin
            r_v1 <= r_vld[DIV_LAT-1];
            r_v2 <= r_v1;
            r_v3 <= r_v2;
            r_v4 <= r_v3;
            r_v5 <= r_v4;
        end
    end

    assign o_m_tvalid = r_v5;
    assign o_m_tdata  = r_out5;

endmodule

FILE: hdl/rbsi_div.sv
// ----------------------------------------------------------------------------
// rbsi_div
// Pipelined signed divider: (num << FRAC_BITS) / den, truncated toward zero,
// saturated to 32 bits. One quotient bit per stage.
// ----------------------------------------------------------------------------
module rbsi_div
    import rbsi_pkg::*;
#(
    parameter int FRAC_BITS = 16
) (
    input  logic               i_clk,
    input  logic               i_ce,
    input  logic signed [32:0] i_num,
    input  logic signed [31:0] i_den,
    output logic signed [31:0] o_quot,
    output logic               o_ovf
);

    localparam int RW = 64 + FRAC_BITS;

    logic [32:0]   n_abs;
    logic [31:0]   d_abs;
    logic [RW-1:0] n_mag;

    logic [RW-1:0]    r_rem  [0:QBITS];
    logic [QBITS-1:0] r_q    [0:QBITS];
    logic [31:0]      r_dabs [0:QBITS];
    logic             r_neg  [0:QBITS];
    logic             r_big  [0:QBITS];
    logic signed [31:0] r_quot;
    logic               r_ovf;

    always_comb begin
        n_abs = i_num[32] ? (~i_num + 33'd1) : i_num;
        d_abs = i_den[31] ? (~i_den + 32'd1) : i_den;
        n_mag = RW'(n_abs) << FRAC_BITS;
    end

    always_ff @(posedge i_clk) begin
        if (i_ce) begin
            r_rem[0]  <= n_mag;
            r_q[0]    <= '0;
            r_dabs[0] <= d_abs;
            r_neg[0]  <= i_num[32] ^ i_den[31];
            // quotient of 2^32 or more saturates whatever the sign
            r_big[0]  <= n_mag >= (RW'(d_abs) << QBITS);
        end
    end

    genvar k;
    generate
        for (k = 1; k <= QBITS; k++) begin : g_stage
            logic [RW-1:0] sub;
            logic          ge;
            assign sub = RW'(r_dabs[k-1]) << (QBITS - k);
            assign ge  = r_rem[k-1] >= sub;
            always_ff @(posedge i_clk) begin
                if (i_ce) begin
                    r_rem[k]  <= ge ? (r_rem[k-1] - sub) : r_rem[k-1];
                    r_q[k]    <= r_q[k-1] | (ge ? (QBITS'(1) << (QBITS - k)) : '0);
                    r_dabs[k] <= r_dabs[k-1];
                    r_neg[k]  <= r_neg[k-1];
                    r_big[k]  <= r_big[k-1];
                end
            end
        end
    endgenerate

    logic [QBITS-1:0] q_fin;
    logic signed [31:0] n_quot;
    logic               n_ovf;

    always_comb begin
        q_fin  = r_q[QBITS];
        n_ovf  = 1'b0;
        n_quot = '0;
        if (r_neg[QBITS]) begin
            if (r_big[QBITS] || q_fin > 32'h8000_0000) begin
                n_ovf  = 1'b1;
                n_quot = 32'sh8000_0000;
            end else begin
                n_quot = $signed(~q_fin + 32'd1);
            end
        end else begin
            if (r_big[QBITS] || q_fin > 32'h7FFF_FFFF) begin
                n_ovf  = 1'b1;
                n_quot = 32'sh7FFF_FFFF;
            end else begin
                n_quot = $signed(q_fin);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ce) begin
            r_quot <= n_quot;
            r_ovf  <= n_ovf;
        end
    end

    assign o_quot = r_quot;
    assign o_ovf  = r_ovf;

endmodule
